/* design/acr_pkg.sv */
// acr_pkg: shared constants, stage types and the cordic arctangent table
// for the axis-angle rotation matrix pipeline; no dependencies
`default_nettype none

package acr_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 17;
    // total depth from the input stage to the output register
    localparam int PIPE_DEPTH   = 1 + SQRT_STEPS + DIV_STEPS + 3;

    localparam logic signed [19:0] CORDIC_GAIN = 20'sd39797;
    localparam logic signed [19:0] PI_Q16      = 20'sd205887;
    localparam logic signed [19:0] HALF_PI_Q16 = 20'sd102944;
    localparam logic signed [15:0] OUT_MAX     = 16'sd16384;

    typedef struct packed {
        logic signed [19:0] x;
        logic signed [19:0] y;
        logic signed [19:0] z;
        logic               flip;
    } t_cordic;

    typedef struct packed {
        logic [31:0] root;
        logic [33:0] rem;
        logic [31:0] bits;
    } t_sqrt;

    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] s;
        logic [16:0] low;
        logic [16:0] q;
    } t_div;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
    } t_mag;

    typedef struct packed {
        logic sx;
        logic sy;
        logic sz;
        logic zero;
    } t_sgn;

    typedef struct packed {
        logic signed [19:0] sn;
        logic signed [19:0] cs;
    } t_sc;

    typedef struct packed {
        logic [16:0] x;
        logic [16:0] y;
        logic [16:0] z;
    } t_quot;

    typedef struct packed {
        logic signed [15:0] r00;
        logic signed [15:0] r01;
        logic signed [15:0] r02;
        logic signed [15:0] r10;
        logic signed [15:0] r11;
        logic signed [15:0] r12;
        logic signed [15:0] r20;
        logic signed [15:0] r21;
        logic signed [15:0] r22;
        logic               zero;
    } t_mat;

    function automatic logic signed [19:0] atan_q16(input int step);
        logic signed [19:0] a;
        unique case (step)
            0:       a = 20'sd51472;
            1:       a = 20'sd30386;
            2:       a = 20'sd16055;
            3:       a = 20'sd8150;
            4:       a = 20'sd4091;
            5:       a = 20'sd2047;
            6:       a = 20'sd1024;
            7:       a = 20'sd512;
            8:       a = 20'sd256;
            9:       a = 20'sd128;
            10:      a = 20'sd64;
            11:      a = 20'sd32;
            12:      a = 20'sd16;
            13:      a = 20'sd8;
            14:      a = 20'sd4;
            15:      a = 20'sd2;
            default: a = 20'sd0;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

/* design/acr_if.sv */
// acr_in_if / acr_out_if: valid-ready channels for angle-axis requests and
// matrix results; no dependencies
`default_nettype none

interface acr_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] angle;
    logic signed [15:0] axis_x;
    logic signed [15:0] axis_y;
    logic signed [15:0] axis_z;

    modport source (output valid, angle, axis_x, axis_y, axis_z, input ready);
    modport sink   (input valid, angle, axis_x, axis_y, axis_z, output ready);
endinterface

interface acr_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] r00;
    logic signed [15:0] r01;
    logic signed [15:0] r02;
    logic signed [15:0] r10;
    logic signed [15:0] r11;
    logic signed [15:0] r12;
    logic signed [15:0] r20;
    logic signed [15:0] r21;
    logic signed [15:0] r22;
    logic               zero_axis;

    modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    zero_axis, input ready);
    modport sink   (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22,
                    zero_axis, output ready);
endinterface

`default_nettype wire

/* design/acr_cordic_cell.sv */
// acr_cordic_cell: one rotation-mode cordic micro-rotation, registered
// depends on acr_pkg
`default_nettype none

module acr_cordic_cell import acr_pkg::*; #(
    parameter int STEP = 0
) (
    input  wire logic    i_clk,
    input  wire logic    i_en,
    input  wire t_cordic i_d,
    output t_cordic      o_d
);

    t_cordic r_d;
    t_cordic n_d;
    logic signed [19:0] w_dx;
    logic signed [19:0] w_dy;
    logic signed [19:0] w_at;

    assign w_dx = i_d.y >>> STEP;
    assign w_dy = i_d.x >>> STEP;
    assign w_at = atan_q16(STEP);

    always_comb begin
        n_d.flip = i_d.flip;
        if (!i_d.z[19]) begin
            n_d.x = i_d.x - w_dx;
            n_d.y = i_d.y + w_dy;
            n_d.z = i_d.z - w_at;
        end else begin
            n_d.x = i_d.x + w_dx;
            n_d.y = i_d.y - w_dy;
            n_d.z = i_d.z + w_at;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* design/acr_sqrt_cell.sv */
// acr_sqrt_cell: one result bit of a digit-by-digit integer square root
// depends on acr_pkg
`default_nettype none

module acr_sqrt_cell import acr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_sqrt i_d,
    output t_sqrt      o_d
);

    t_sqrt       r_d;
    t_sqrt       n_d;
    logic [34:0] w_t;
    logic [34:0] w_trial;
    logic [34:0] w_diff;
    logic        w_ge;

    assign w_t     = {i_d.rem[32:0], i_d.bits[31:30]};
    assign w_trial = {1'b0, i_d.root, 2'b01};
    assign w_ge    = (w_t >= w_trial);
    assign w_diff  = w_t - w_trial;

    always_comb begin
        n_d.rem  = w_ge ? w_diff[33:0] : w_t[33:0];
        n_d.root = {i_d.root[30:0], w_ge};
        n_d.bits = {i_d.bits[29:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* design/acr_div_cell.sv */
// acr_div_cell: one quotient bit of a restoring divider
// depends on acr_pkg
`default_nettype none

module acr_div_cell import acr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_en,
    input  wire t_div i_d,
    output t_div      o_d
);

    t_div        r_d;
    t_div        n_d;
    logic [32:0] w_t;
    logic [32:0] w_diff;
    logic        w_ge;

    assign w_t    = {i_d.rem, i_d.low[16]};
    assign w_ge   = (w_t >= {1'b0, i_d.s});
    assign w_diff = w_t - {1'b0, i_d.s};

    always_comb begin
        n_d.rem = w_ge ? w_diff[31:0] : w_t[31:0];
        n_d.s   = i_d.s;
        n_d.low = {i_d.low[15:0], 1'b0};
        n_d.q   = {i_d.q[15:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d <= n_d;
        end
    end

    assign o_d = r_d;

endmodule

`default_nettype wire

/* design/acr_mat.sv */
// acr_mat: three-stage matrix entry builder (products, second products,
// sums with rounding and saturation); depends on acr_pkg
`default_nettype none

module acr_mat import acr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_en,
    input  wire t_quot i_q,
    input  wire t_sgn  i_sgn,
    input  wire t_sc   i_sc,
    output t_mat       o_m
);

    logic signed [17:0] w_ux, w_uy, w_uz;
    logic signed [20:0] w_t;

    logic signed [38:0] r_tx, r_ty, r_tz;
    logic signed [37:0] r_sx, r_sy, r_sz;
    logic signed [17:0] r_ux, r_uy, r_uz;
    logic signed [19:0] r_cs;
    logic               r_zero;

    logic signed [56:0] r_txx, r_txy, r_txz, r_tyy, r_tyz, r_tzz;
    logic signed [37:0] r2_sx, r2_sy, r2_sz;
    logic signed [19:0] r2_cs;
    logic               r2_zero;

    t_mat r_m;
    t_mat n_m;

    function automatic logic signed [15:0] to_q14(input logic signed [57:0] v);
        logic signed [57:0] w;
        logic signed [23:0] r;
        logic signed [15:0] o;
        w = v + 58'sd8589934592;
        r = 24'(w >>> 34);
        if (r > 24'sd16384) begin
            o = OUT_MAX;
        end else if (r < -24'sd16384) begin
            o = -OUT_MAX;
        end else begin
            o = r[15:0];
        end
        return o;
    endfunction

    assign w_ux = i_sgn.sx ? -$signed({1'b0, i_q.x}) : $signed({1'b0, i_q.x});
    assign w_uy = i_sgn.sy ? -$signed({1'b0, i_q.y}) : $signed({1'b0, i_q.y});
    assign w_uz = i_sgn.sz ? -$signed({1'b0, i_q.z}) : $signed({1'b0, i_q.z});
    assign w_t  = 21'sd65536 - 21'(i_sc.cs);

    // first products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tx   <= w_t * w_ux;
            r_ty   <= w_t * w_uy;
            r_tz   <= w_t * w_uz;
            r_sx   <= i_sc.sn * w_ux;
            r_sy   <= i_sc.sn * w_uy;
            r_sz   <= i_sc.sn * w_uz;
            r_ux   <= w_ux;
            r_uy   <= w_uy;
            r_uz   <= w_uz;
            r_cs   <= i_sc.cs;
            r_zero <= i_sgn.zero;
        end
    end

    // second products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_txx   <= r_tx * r_ux;
            r_txy   <= r_tx * r_uy;
            r_txz   <= r_tx * r_uz;
            r_tyy   <= r_ty * r_uy;
            r_tyz   <= r_ty * r_uz;
            r_tzz   <= r_tz * r_uz;
            r2_sx   <= r_sx;
            r2_sy   <= r_sy;
            r2_sz   <= r_sz;
            r2_cs   <= r_cs;
            r2_zero <= r_zero;
        end
    end

    always_comb begin
        logic signed [57:0] c;
        logic signed [57:0] sx, sy, sz;
        c  = 58'(r2_cs) <<< 32;
        sx = 58'(r2_sx) <<< 16;
        sy = 58'(r2_sy) <<< 16;
        sz = 58'(r2_sz) <<< 16;
        n_m.zero = r2_zero;
        if (r2_zero) begin
            n_m.r00 = OUT_MAX;  n_m.r01 = '0;       n_m.r02 = '0;
            n_m.r10 = '0;       n_m.r11 = OUT_MAX;  n_m.r12 = '0;
            n_m.r20 = '0;       n_m.r21 = '0;       n_m.r22 = OUT_MAX;
        end else begin
            n_m.r00 = to_q14(58'(r_txx) + c);
            n_m.r01 = to_q14(58'(r_txy) - sz);
            n_m.r02 = to_q14(58'(r_txz) + sy);
            n_m.r10 = to_q14(58'(r_txy) + sz);
            n_m.r11 = to_q14(58'(r_tyy) + c);
            n_m.r12 = to_q14(58'(r_tyz) - sx);
            n_m.r20 = to_q14(58'(r_txz) - sy);
            n_m.r21 = to_q14(58'(r_tyz) + sx);
            n_m.r22 = to_q14(58'(r_tzz) + c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_m <= n_m;
        end
    end

    assign o_m = r_m;

endmodule

`default_nettype wire

/* design/axis_angle_rotation_matrix.sv */
// axis_angle_rotation_matrix: top level of the axis-angle to rotation matrix pipeline
// depends on acr_pkg, acr_if, acr_cordic_cell, acr_sqrt_cell, acr_div_cell, acr_mat
//
//  channel | dir | payload                          | transfer when
//  i_in    | in  | angle, axis_x, axis_y, axis_z    | valid && ready
//  o_out   | out | r00..r22, zero_axis              | valid && ready
//
// one transfer in per cycle while no result waits unread at the output
// results pass the input stage, 32-cell square root chain, 17-cell divider chain and acr_mat
// the cordic chain (16 cells) runs beside the square root and is delayed to align
// the whole chain advances together; it holds only while a result waits unread
// synchronous active-low reset clears the valid line only, no clearing pass
`default_nettype none

module axis_angle_rotation_matrix import acr_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    acr_in_if.sink     i_in,
    acr_out_if.source  o_out
);

    logic w_en;
    logic [PIPE_DEPTH-1:0] r_vld;

    // input stage
    logic signed [19:0] w_ang;
    logic [15:0] w_mx, w_my, w_mz;
    logic [31:0] w_px, w_py, w_pz;
    logic [33:0] w_sum;
    t_cordic w_cor_in;

    t_cordic r_cor_a;
    t_sqrt   r_sq_a;
    t_mag    r_mag_a;
    t_sgn    r_sgn_a;

    // cell chains
    t_cordic w_cor [CORDIC_STEPS+1];
    t_sqrt   w_sq  [SQRT_STEPS+1];
    t_div    w_dx  [DIV_STEPS+1];
    t_div    w_dy  [DIV_STEPS+1];
    t_div    w_dz  [DIV_STEPS+1];

    // alignment shift lines
    t_mag r_mag_dly [SQRT_STEPS];
    t_sgn r_sgn_dly [SQRT_STEPS+DIV_STEPS];
    t_sc  r_sc_dly  [SQRT_STEPS+DIV_STEPS-CORDIC_STEPS];
    t_sc  w_sc_cor;

    logic [31:0] w_s;
    t_mag  w_mag;
    t_quot w_q;
    t_mat  w_m;

    // the chain moves unless a result is waiting and not taken
    assign w_en        = !r_vld[PIPE_DEPTH-1] || o_out.ready;
    assign i_in.ready  = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[PIPE_DEPTH-2:0], i_in.valid};
        end
    end

    // angle to q16 and quadrant fold
    assign w_ang = {{1{i_in.angle[15]}}, i_in.angle, 3'b000};

    always_comb begin
        w_cor_in.x = CORDIC_GAIN;
        w_cor_in.y = '0;
        if (w_ang > HALF_PI_Q16) begin
            w_cor_in.z    = PI_Q16 - w_ang;
            w_cor_in.flip = 1'b1;
        end else if (w_ang < -HALF_PI_Q16) begin
            w_cor_in.z    = -PI_Q16 - w_ang;
            w_cor_in.flip = 1'b1;
        end else begin
            w_cor_in.z    = w_ang;
            w_cor_in.flip = 1'b0;
        end
    end

    // axis magnitudes and squared length
    assign w_mx  = i_in.axis_x[15] ? 16'(-i_in.axis_x) : i_in.axis_x;
    assign w_my  = i_in.axis_y[15] ? 16'(-i_in.axis_y) : i_in.axis_y;
    assign w_mz  = i_in.axis_z[15] ? 16'(-i_in.axis_z) : i_in.axis_z;
    assign w_px  = w_mx * w_mx;
    assign w_py  = w_my * w_my;
    assign w_pz  = w_mz * w_mz;
    assign w_sum = {2'b00, w_px} + {2'b00, w_py} + {2'b00, w_pz};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cor_a      <= w_cor_in;
            r_sq_a.root  <= '0;
            r_sq_a.rem   <= '0;
            r_sq_a.bits  <= w_sum[31:0];
            r_mag_a.x    <= w_mx;
            r_mag_a.y    <= w_my;
            r_mag_a.z    <= w_mz;
            r_sgn_a.sx   <= i_in.axis_x[15];
            r_sgn_a.sy   <= i_in.axis_y[15];
            r_sgn_a.sz   <= i_in.axis_z[15];
            r_sgn_a.zero <= (i_in.axis_x == '0) && (i_in.axis_y == '0)
                            && (i_in.axis_z == '0);
        end
    end

    // sine and cosine
    assign w_cor[0] = r_cor_a;
    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cor
        acr_cordic_cell #(.STEP(k)) u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_cor[k]),
            .o_d   (w_cor[k+1])
        );
    end

    assign w_sc_cor.sn = w_cor[CORDIC_STEPS].y;
    assign w_sc_cor.cs = w_cor[CORDIC_STEPS].flip ? -w_cor[CORDIC_STEPS].x
                                                  : w_cor[CORDIC_STEPS].x;

    // length: sqrt(sum << 32), one root bit per cell
    assign w_sq[0] = r_sq_a;
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sq
        acr_sqrt_cell u_cell (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_d   (w_sq[k]),
            .o_d   (w_sq[k+1])
        );
    end

    // shift lines keep side data in step with the chains
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag_dly[0] <= r_mag_a;
            for (int k = 1; k < SQRT_STEPS; k++) begin
                r_mag_dly[k] <= r_mag_dly[k-1];
            end
            r_sgn_dly[0] <= r_sgn_a;
            for (int k = 1; k < SQRT_STEPS + DIV_STEPS; k++) begin
                r_sgn_dly[k] <= r_sgn_dly[k-1];
            end
            r_sc_dly[0] <= w_sc_cor;
            for (int k = 1; k < SQRT_STEPS + DIV_STEPS - CORDIC_STEPS; k++) begin
                r_sc_dly[k] <= r_sc_dly[k-1];
            end
        end
    end

    // unit components: (mag << 32 + s/2) / s, high part preloaded, low 17 bits shifted in
    assign w_s   = w_sq[SQRT_STEPS].root;
    assign w_mag = r_mag_dly[SQRT_STEPS-1];

    assign w_dx[0] = '{rem: {1'b0, w_mag.x, 15'b0} + {18'b0, w_s[31:18]},
                       s: w_s, low: w_s[17:1], q: '0};
    assign w_dy[0] = '{rem: {1'b0, w_mag.y, 15'b0} + {18'b0, w_s[31:18]},
                       s: w_s, low: w_s[17:1], q: '0};
    assign w_dz[0] = '{rem: {1'b0, w_mag.z, 15'b0} + {18'b0, w_s[31:18]},
                       s: w_s, low: w_s[17:1], q: '0};

    for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
        acr_div_cell u_cx (.i_clk(i_clk), .i_en(w_en), .i_d(w_dx[k]), .o_d(w_dx[k+1]));
        acr_div_cell u_cy (.i_clk(i_clk), .i_en(w_en), .i_d(w_dy[k]), .o_d(w_dy[k+1]));
        acr_div_cell u_cz (.i_clk(i_clk), .i_en(w_en), .i_d(w_dz[k]), .o_d(w_dz[k+1]));
    end

    assign w_q.x = w_dx[DIV_STEPS].q;
    assign w_q.y = w_dy[DIV_STEPS].q;
    assign w_q.z = w_dz[DIV_STEPS].q;

    // matrix entries, last stage is the output register
    acr_mat u_mat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_q   (w_q),
        .i_sgn (r_sgn_dly[SQRT_STEPS+DIV_STEPS-1]),
        .i_sc  (r_sc_dly[SQRT_STEPS+DIV_STEPS-CORDIC_STEPS-1]),
        .o_m   (w_m)
    );

    assign o_out.valid     = r_vld[PIPE_DEPTH-1];
    assign o_out.r00       = w_m.r00;
    assign o_out.r01       = w_m.r01;
    assign o_out.r02       = w_m.r02;
    assign o_out.r10       = w_m.r10;
    assign o_out.r11       = w_m.r11;
    assign o_out.r12       = w_m.r12;
    assign o_out.r20       = w_m.r20;
    assign o_out.r21       = w_m.r21;
    assign o_out.r22       = w_m.r22;
    assign o_out.zero_axis = w_m.zero;

    // an accepted transfer always enters the first stage
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[0])
        else $error("accepted transfer missing from first stage");

    // a stall freezes the whole valid line
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_vld))
        else $error("valid line moved during stall");

    // zero axis gives the identity; checks the diagonal and r01, r12, r20
    a_zero_identity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.zero_axis |->
            o_out.r00 == OUT_MAX && o_out.r11 == OUT_MAX && o_out.r22 == OUT_MAX
            && o_out.r01 == 16'sd0 && o_out.r12 == 16'sd0 && o_out.r20 == 16'sd0)
        else $error("zero axis result is not the identity");

    // saturation keeps every diagonal entry within one
    a_diag_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            o_out.r00 <= OUT_MAX && o_out.r00 >= -OUT_MAX
            && o_out.r11 <= OUT_MAX && o_out.r11 >= -OUT_MAX
            && o_out.r22 <= OUT_MAX && o_out.r22 >= -OUT_MAX)
        else $error("diagonal entry outside saturation range");

endmodule

`default_nettype wire

/* bench/acr_matrix_checker.sv */
// acr_matrix_checker: watches the request and matrix channels, predicts each
// rotation matrix and compares it with the block's result
// depends on acr_pkg and acr_if
`default_nettype none

module acr_matrix_checker import acr_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    acr_in_if         i_req,
    acr_out_if        i_mat,
    output int        o_fail_count,
    output int        o_pending
);

    localparam longint ONE_Q16 = 65536;
    localparam longint LIM_Q14 = 16384;

    t_mat pending_mats[$];

    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= root + bitv) begin
                n    = n - (root + bitv);
                root = (root >> 1) + bitv;
            end else begin
                root = root >> 1;
            end
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic longint unit_part(input longint a, input longint unsigned s);
        longint unsigned mag;
        longint q;
        mag = (a < 0) ? -a : a;
        q   = longint'(((mag << 32) + (s >> 1)) / s);
        return (a < 0) ? -q : q;
    endfunction

    function automatic logic signed [15:0] round_q14(input longint v);
        longint r;
        r = (v + (64'sd1 <<< 33)) >>> 34;
        if (r > LIM_Q14) r = LIM_Q14;
        if (r < -LIM_Q14) r = -LIM_Q14;
        return r[15:0];
    endfunction

    // fixed-length cordic with quadrant fold
    function automatic void cordic_sin_cos(input longint ang, output longint sn,
                                           output longint cs);
        longint x, y, z, dx, dy;
        bit flip;
        z = ang * 8;
        x = CORDIC_GAIN;
        y = 0;
        flip = 0;
        if (z > HALF_PI_Q16) begin
            z = PI_Q16 - z;
            flip = 1;
        end else if (z < -HALF_PI_Q16) begin
            z = -PI_Q16 - z;
            flip = 1;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - atan_tab(i);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + atan_tab(i);
            end
        end
        sn = y;
        cs = flip ? -x : x;
    endfunction

    function automatic longint atan_tab(input int i);
        longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                            256, 128, 64, 32, 16, 8, 4, 2};
        return tab[i];
    endfunction

    function automatic t_mat rodrigues_matrix(input logic signed [15:0] ang,
                                              input logic signed [15:0] ax,
                                              input logic signed [15:0] ay,
                                              input logic signed [15:0] az);
        t_mat m;
        longint unsigned sum, s;
        longint x, y, z, sn, cs, t, ct;
        m = '0;
        if (ax == 0 && ay == 0 && az == 0) begin
            m.r00 = OUT_MAX;
            m.r11 = OUT_MAX;
            m.r22 = OUT_MAX;
            m.zero = 1'b1;
            return m;
        end
        sum = longint'(ax) * ax + longint'(ay) * ay + longint'(az) * az;
        s = int_sqrt(sum << 32);
        x = unit_part(ax, s);
        y = unit_part(ay, s);
        z = unit_part(az, s);
        cordic_sin_cos(ang, sn, cs);
        t  = ONE_Q16 - cs;
        ct = cs * (64'sd1 <<< 32);
        m.r00 = round_q14(t * x * x + ct);
        m.r01 = round_q14(t * x * y - sn * z * ONE_Q16);
        m.r02 = round_q14(t * z * x + sn * y * ONE_Q16);
        m.r10 = round_q14(t * x * y + sn * z * ONE_Q16);
        m.r11 = round_q14(t * y * y + ct);
        m.r12 = round_q14(t * y * z - sn * x * ONE_Q16);
        m.r20 = round_q14(t * z * x - sn * y * ONE_Q16);
        m.r21 = round_q14(t * y * z + sn * x * ONE_Q16);
        m.r22 = round_q14(t * z * z + ct);
        return m;
    endfunction

    function automatic void check_field(input string fname, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", fname, want, got);
            o_fail_count++;
        end
    endfunction

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_mat want;
        if (i_rst_n && i_req.valid && i_req.ready)
            pending_mats.push_back(rodrigues_matrix(i_req.angle, i_req.axis_x,
                                                    i_req.axis_y, i_req.axis_z));
        if (i_rst_n && i_mat.valid && i_mat.ready) begin
            if (pending_mats.size() == 0) begin
                $error("matrix transfer with no request outstanding");
                o_fail_count++;
            end else begin
                want = pending_mats.pop_front();
                check_field("r00", want.r00, i_mat.r00);
                check_field("r01", want.r01, i_mat.r01);
                check_field("r02", want.r02, i_mat.r02);
                check_field("r10", want.r10, i_mat.r10);
                check_field("r11", want.r11, i_mat.r11);
                check_field("r12", want.r12, i_mat.r12);
                check_field("r20", want.r20, i_mat.r20);
                check_field("r21", want.r21, i_mat.r21);
                check_field("r22", want.r22, i_mat.r22);
                check_field("zero_axis", want.zero, i_mat.zero_axis);
            end
        end
        o_pending = pending_mats.size();
    end

endmodule

`default_nettype wire

/* bench/tb_axis_angle_rotation_matrix.sv */
// tb_axis_angle_rotation_matrix: stimulus, handshake pacing and verdict for
// the rotation matrix pipeline; depends on acr_pkg, acr_if and acr_matrix_checker
`default_nettype none

module tb_axis_angle_rotation_matrix import acr_pkg::*;;

    localparam int N_RANDOM   = 1200;
    localparam int WDOG_LIMIT = 5000;   // cycles with no transfer on either side
    localparam int HOLD_LEN   = 300;    // long receiver hold-off, well past pipe depth

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;            // chance of an idle cycle before each offer
    int   recv_stall_pct = 0;           // chance of ready low in a cycle
    bit   hold_req = 0;
    bit   stim_done = 0;
    int   quiet_cycles = 0;

    acr_in_if  req_ch();
    acr_out_if mat_ch();

    axis_angle_rotation_matrix uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_ch),
        .o_out   (mat_ch)
    );

    acr_matrix_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_mat        (mat_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #6 i_clk = ~i_clk;

    // offer one request from the falling edge and hold it until transferred
    task automatic send_req(input logic [15:0] ang, input logic [15:0] ax,
                            input logic [15:0] ay, input logic [15:0] az);
        @(negedge i_clk);
        req_ch.valid  <= 1'b1;
        req_ch.angle  <= ang;
        req_ch.axis_x <= ax;
        req_ch.axis_y <= ay;
        req_ch.axis_z <= az;
        do @(posedge i_clk); while (!req_ch.ready);
        // idle cycles drawn one at a time, so the idle share matches the chance
        while ($urandom_range(99) < send_idle_pct) begin
            @(negedge i_clk);
            req_ch.valid <= 1'b0;
        end
    endtask

    function automatic logic [15:0] rand_axis(input int kind);
        case (kind)
            0:       return 16'd0;
            1:       return 16'($signed($urandom_range(0, 1024)) - 512);
            default: return 16'($urandom);
        endcase
    endfunction

    // receiver pacing, with one long hold-off on request
    initial begin
        mat_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                mat_ch.ready <= 1'b0;
                repeat (HOLD_LEN) @(negedge i_clk);
                hold_req = 0;
            end
            mat_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog on stalled traffic
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (mat_ch.valid && mat_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WDOG_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int kind;
        req_ch.valid  = 1'b0;
        req_ch.angle  = '0;
        req_ch.axis_x = '0;
        req_ch.axis_y = '0;
        req_ch.axis_z = '0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // zero axis, angle ignored
        send_req(16'd0, 16'd0, 16'd0, 16'd0);
        send_req(16'h8000, 16'd0, 16'd0, 16'd0);
        send_req(16'h7fff, 16'd0, 16'd0, 16'd0);
        // angle extremes and fold boundaries on unit axes and one diagonal axis
        send_req(16'h8000, 16'h0100, 16'd0, 16'd0);
        send_req(16'h7fff, 16'd0, 16'h0100, 16'd0);
        send_req(16'd0, 16'd0, 16'd0, 16'h0100);
        send_req(16'd12868, 16'h0100, 16'd0, 16'd0);     // exactly half pi
        send_req(16'd12869, 16'd0, 16'h0100, 16'd0);     // just past, folds
        send_req(-16'sd12868, 16'd0, 16'd0, 16'h0100);
        send_req(-16'sd12869, 16'h0100, 16'h0100, 16'd0);
        send_req(16'd25736, 16'd0, 16'd0, 16'h0100);     // near pi
        send_req(-16'sd25736, 16'd0, 16'h0100, 16'd0);
        // axis component extremes
        send_req(16'd6434, 16'h8000, 16'h8000, 16'h8000);
        send_req(16'd6434, 16'h7fff, 16'h7fff, 16'h7fff);
        send_req(-16'sd6434, 16'h8000, 16'h7fff, 16'd1);
        send_req(16'd1000, 16'd1, 16'd0, 16'd0);
        send_req(16'd1000, 16'hffff, 16'hffff, 16'hffff);
        send_req(16'h7fff, 16'h0001, 16'h7fff, 16'h8000);
        send_req(16'h8000, 16'h8000, 16'd0, 16'd1);
        send_req(16'd4321, 16'h0100, 16'hff00, 16'h0080);

        // receiver holds off while requests keep coming, filling the pipe
        hold_req = 1;
        for (int n = 0; n < N_RANDOM; n++) begin
            case (n / (N_RANDOM / 4))
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            kind = $urandom_range(99);
            if (kind < 8)
                send_req(16'($urandom), 16'd0, 16'd0, 16'd0);
            else if (kind < 40)
                send_req(16'($urandom), rand_axis(1), rand_axis(1), rand_axis(1));
            else
                send_req(16'($urandom), rand_axis(2), rand_axis(2), rand_axis(2));
        end
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        recv_stall_pct = 0;

        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
